// ----- rtl/qdec_pkg.sv -----
// Shared types and constants for the quadrature decoder with statistics.
`default_nettype none

package qdec_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int TIME_WIDTH  = 64;

   localparam int REQ_DATA_WIDTH = 72;
   localparam int RSP_DATA_WIDTH = 360;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_EDGE   = 2'd1,
      OP_LOAD   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   localparam logic CHAN_A = 1'b0;

   // Signed step codes.
   localparam logic [1:0] STEP_NONE = 2'b00;
   localparam logic [1:0] STEP_UP   = 2'b01;
   localparam logic [1:0] STEP_DOWN = 2'b11;

   typedef struct packed {
      op_type                  op;
      logic [1:0]              sample_state;
      logic                    edge_channel;
      logic                    edge_level;
      logic [TIME_WIDTH-1:0]   timestamp;
   } item_type;

   typedef struct packed {
      logic [1:0]  step_delta;
      logic [31:0] position_count;
      logic [31:0] valid_transitions;
      logic [31:0] invalid_transitions;
      logic [31:0] a_edge_total;
      logic [31:0] b_edge_total;
      logic [1:0]  direction;
      logic [63:0] last_step_time;
      logic [63:0] last_a_time;
      logic [63:0] last_b_time;
      logic [1:0]  current_ab;
   } snap_type;

endpackage

`default_nettype wire

// ----- rtl/qdec_core.sv -----
// Decoder state registers and the combinational update for one word.
`default_nettype none

module qdec_core import qdec_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire item_type item,
   input  wire logic     reverse,
   output snap_type      snap
);

   logic [1:0]             ab_ff, ab_in;
   logic [COUNT_WIDTH-1:0] position_ff, position_in;
   logic [COUNT_WIDTH-1:0] valid_ff, valid_in;
   logic [COUNT_WIDTH-1:0] invalid_ff, invalid_in;
   logic [COUNT_WIDTH-1:0] a_edges_ff, a_edges_in;
   logic [COUNT_WIDTH-1:0] b_edges_ff, b_edges_in;
   logic [1:0]             direction_ff, direction_in;
   logic [TIME_WIDTH-1:0]  step_time_ff, step_time_in;
   logic [TIME_WIDTH-1:0]  a_time_ff, a_time_in;
   logic [TIME_WIDTH-1:0]  b_time_ff, b_time_in;

   logic [1:0] cand_ab;
   logic       decode_en;
   logic [1:0] diff;
   logic       fwd;
   logic [1:0] delta;

   // Forward Gray order is 0 -> 1 -> 3 -> 2 -> 0.
   always_comb begin
      case (ab_ff)
         2'd0:    fwd = (cand_ab == 2'd1);
         2'd1:    fwd = (cand_ab == 2'd3);
         2'd3:    fwd = (cand_ab == 2'd2);
         default: fwd = (cand_ab == 2'd0);
      endcase
   end

   always_comb begin
      ab_in        = ab_ff;
      position_in  = position_ff;
      valid_in     = valid_ff;
      invalid_in   = invalid_ff;
      a_edges_in   = a_edges_ff;
      b_edges_in   = b_edges_ff;
      direction_in = direction_ff;
      step_time_in = step_time_ff;
      a_time_in    = a_time_ff;
      b_time_in    = b_time_ff;
      cand_ab      = item.sample_state;
      decode_en    = 1'b0;
      delta        = STEP_NONE;
      diff         = 2'b00;

      unique case (item.op)
         OP_SAMPLE: begin
            decode_en = 1'b1;
         end
         OP_EDGE: begin
            decode_en = 1'b1;
            if (item.edge_channel == CHAN_A) begin
               a_edges_in = a_edges_ff + COUNT_WIDTH'(1);
               a_time_in  = item.timestamp;
               cand_ab    = {item.edge_level, ab_ff[0]};
            end else begin
               b_edges_in = b_edges_ff + COUNT_WIDTH'(1);
               b_time_in  = item.timestamp;
               cand_ab    = {ab_ff[1], item.edge_level};
            end
         end
         OP_LOAD: begin
            ab_in = item.sample_state;
         end
         OP_CLEAR: begin
            position_in  = '0;
            valid_in     = '0;
            invalid_in   = '0;
            a_edges_in   = '0;
            b_edges_in   = '0;
            direction_in = STEP_NONE;
            step_time_in = '0;
            a_time_in    = '0;
            b_time_in    = '0;
         end
         default: ;
      endcase

      if (decode_en) begin
         ab_in = cand_ab;
         diff  = ab_ff ^ cand_ab;
         if (diff == 2'b11) begin
            invalid_in   = invalid_ff + COUNT_WIDTH'(1);
            direction_in = STEP_NONE;
         end else if (diff != 2'b00) begin
            delta        = (fwd ^ reverse) ? STEP_UP : STEP_DOWN;
            position_in  = position_ff + {{(COUNT_WIDTH-2){delta[1]}}, delta};
            valid_in     = valid_ff + COUNT_WIDTH'(1);
            direction_in = delta;
            step_time_in = item.timestamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ab_ff        <= '0;
         position_ff  <= '0;
         valid_ff     <= '0;
         invalid_ff   <= '0;
         a_edges_ff   <= '0;
         b_edges_ff   <= '0;
         direction_ff <= '0;
         step_time_ff <= '0;
         a_time_ff    <= '0;
         b_time_ff    <= '0;
      end else if (advance) begin
         ab_ff        <= ab_in;
         position_ff  <= position_in;
         valid_ff     <= valid_in;
         invalid_ff   <= invalid_in;
         a_edges_ff   <= a_edges_in;
         b_edges_ff   <= b_edges_in;
         direction_ff <= direction_in;
         step_time_ff <= step_time_in;
         a_time_ff    <= a_time_in;
         b_time_ff    <= b_time_in;
      end
   end

   // Snapshot reflects the state after this word.
   always_comb begin
      snap.step_delta          = delta;
      snap.position_count      = position_in;
      snap.valid_transitions   = valid_in;
      snap.invalid_transitions = invalid_in;
      snap.a_edge_total        = a_edges_in;
      snap.b_edge_total        = b_edges_in;
      snap.direction           = direction_in;
      snap.last_step_time      = step_time_in;
      snap.last_a_time         = a_time_in;
      snap.last_b_time         = b_time_in;
      snap.current_ab          = ab_in;
   end

endmodule

`default_nettype wire

// ----- rtl/quadrature_decoder_with_stats.sv -----
// Top level: x4 quadrature decoder with edge and transition statistics.
//
//   port group | dir | contents
//   req_*      | in  | one operation word: op in tuser, sample/edge/time in tdata
//   rsp_*      | out | one snapshot word per request word
//   csr_*      | in  | reverse_direction bit, write only
//
// One word per cycle sustained while rsp is not stalled; each word is taken
// into the input register and then decoded into the output register, so its
// snapshot reaches rsp only after the word has passed through both registers.
// The longest combinational path is the 32-bit counter adds plus the Gray decode.
// Synchronous active-high reset clears all counters, times, the A/B state,
// and the direction bit. A stalled rsp holds its word; the input register
// keeps taking words as long as the output can drain.
`default_nettype none

module quadrature_decoder_with_stats import qdec_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // tdata, low bit up: sample_state[1:0], edge_channel, edge_level,
   // timestamp[63:0], zero pad[3:0]
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // tuser: op[1:0]
   input  wire logic [1:0]                req_tuser,

   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // tdata, low bit up: step_delta[1:0], position_count[31:0],
   // valid_transitions[31:0], invalid_transitions[31:0], a_edge_total[31:0],
   // b_edge_total[31:0], direction[1:0], last_step_time[63:0],
   // last_a_time[63:0], last_b_time[63:0], current_ab[1:0], zero pad[1:0]
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,

   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_wr_data
);

   logic     reverse_ff;
   logic     s1_valid_ff;
   item_type s1_item_ff;
   logic     rsp_valid_ff;
   snap_type rsp_snap_ff;
   snap_type snap_in;
   logic     advance;
   logic     req_fire;

   // Stage 1 moves into the result register when that register is free
   // or being drained this cycle.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
      end else if (csr_wr_en) begin
         reverse_ff <= csr_wr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.op           <= op_type'(req_tuser);
         s1_item_ff.sample_state <= req_tdata[1:0];
         s1_item_ff.edge_channel <= req_tdata[2];
         s1_item_ff.edge_level   <= req_tdata[3];
         s1_item_ff.timestamp    <= req_tdata[67:4];
      end
   end

   qdec_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .reverse (reverse_ff),
      .snap    (snap_in)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_snap_ff <= snap_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_snap_ff.current_ab,
                        rsp_snap_ff.last_b_time,
                        rsp_snap_ff.last_a_time,
                        rsp_snap_ff.last_step_time,
                        rsp_snap_ff.direction,
                        rsp_snap_ff.b_edge_total,
                        rsp_snap_ff.a_edge_total,
                        rsp_snap_ff.invalid_transitions,
                        rsp_snap_ff.valid_transitions,
                        rsp_snap_ff.position_count,
                        rsp_snap_ff.step_delta};

   // A full input register with room downstream must produce a result.
   a_advance_out : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (!rsp_valid_ff || rsp_tready) |=> rsp_valid_ff)
      else $error("stage 1 word did not reach the result register");

   // Input only back-pressures when both stages are full and rsp stalls.
   a_ready_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("req_tready low without a full pipeline");

   // A step is never the unused code and always sets the direction.
   a_step_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_snap_ff.step_delta != 2'b10)
      else $error("illegal step_delta code");

   a_step_dir : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_snap_ff.step_delta != STEP_NONE
         |-> rsp_snap_ff.direction == rsp_snap_ff.step_delta)
      else $error("direction does not follow step");

endmodule

`default_nettype wire
